[hdl/lc2d_pkg.sv]
package lc2d_pkg;

    localparam int MOVE_LIMIT = 8;
    localparam int MOVE_CNT_W = 4;
    localparam int QUOT_LIMIT_LOG2 = 40;

    localparam logic [3:0] OC_LEFT   = 4'h1;
    localparam logic [3:0] OC_RIGHT  = 4'h2;
    localparam logic [3:0] OC_BOTTOM = 4'h4;
    localparam logic [3:0] OC_TOP    = 4'h8;

    localparam logic ADDR_WINDOW_LOW  = 1'b0;
    localparam logic ADDR_WINDOW_HIGH = 1'b1;

    // datapath commands from the controller
    typedef struct packed {
        logic load;       // capture endpoints, compute outcodes
        logic prep;       // swap if needed, select edge, set up divide
        logic div_step;   // one restoring divide step
        logic finish;     // apply quotient, recompute outcode of endpoint 1
        logic result;     // latch result into output register
        logic result_vis; // visible flag for the result
    } lc2d_cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic all_inside;
        logic trivial_rej;
        logic div_last;
    } lc2d_sts_t;

endpackage

[hdl/lc2d_datapath.sv]
module lc2d_datapath
    import lc2d_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lc2d_cmd_t                     cmd,
    output lc2d_sts_t                     sts,
    input  logic signed [COORD_WIDTH-1:0] window_low,
    input  logic signed [COORD_WIDTH-1:0] window_high,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output logic                          visible,
    output logic signed [COORD_WIDTH-1:0] out_start_x,
    output logic signed [COORD_WIDTH-1:0] out_start_y,
    output logic signed [COORD_WIDTH-1:0] out_end_x,
    output logic signed [COORD_WIDTH-1:0] out_end_y
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;          // difference width
    localparam int PW = 2 * DW;          // product width
    localparam int SW = (CW + 2 > QUOT_LIMIT_LOG2 + 2) ? CW + 2 : QUOT_LIMIT_LOG2 + 2;
    localparam int CNT_W = $clog2(PW + 1);

    logic signed [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [3:0]           c1_reg, c2_reg;
    logic signed [CW-1:0] base_reg;
    logic                 axis_y_reg;   // 1: moving x to a y edge
    logic signed [CW-1:0] edge_reg;
    logic                 neg_reg;
    logic [PW-1:0]        dvd_reg;      // product magnitude, shifted out msb first
    logic [DW-1:0]        den_reg;
    logic [DW:0]          rem_reg;
    logic [PW-1:0]        quo_reg;
    logic                 zero_den_reg;
    logic [CNT_W-1:0]     cnt_reg;

    function automatic logic [3:0] outcode(
        input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
        input logic signed [CW-1:0] lo, input logic signed [CW-1:0] hi);
        logic [3:0] c;
        c = 4'h0;
        if (x < lo)      c = c | OC_LEFT;
        else if (x > hi) c = c | OC_RIGHT;
        if (y < lo)      c = c | OC_BOTTOM;
        else if (y > hi) c = c | OC_TOP;
        return c;
    endfunction

    function automatic logic [DW-1:0] magd(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // endpoint selection after optional swap
    logic                 swap;
    logic signed [CW-1:0] ax, ay, bx, by;
    logic [3:0]           ac;
    logic signed [DW-1:0] span, num, den;
    logic                 sel_y;
    logic signed [CW-1:0] edge_v;
    logic [PW-1:0]        prod;

    always_comb
    begin
        swap = (c1_reg == 4'h0);
        ax = swap ? x2_reg : x1_reg;
        ay = swap ? y2_reg : y1_reg;
        bx = swap ? x1_reg : x2_reg;
        by = swap ? y1_reg : y2_reg;
        ac = swap ? c2_reg : c1_reg;
        sel_y = ((ac & (OC_LEFT | OC_RIGHT)) == 4'h0);
        if ((ac & OC_LEFT) != 4'h0 || ((ac & OC_RIGHT) == 4'h0 && (ac & OC_BOTTOM) != 4'h0))
            edge_v = window_low;
        else
            edge_v = window_high;
        if (!sel_y)
        begin
            span = DW'(by) - DW'(ay);
            num  = DW'(edge_v) - DW'(ax);
            den  = DW'(bx) - DW'(ax);
        end
        else
        begin
            span = DW'(bx) - DW'(ax);
            num  = DW'(edge_v) - DW'(ay);
            den  = DW'(by) - DW'(ay);
        end
        // one multiplier, at most 17x17 for the default width
        prod = PW'(magd(span)) * PW'(magd(num));
    end

    // restoring division step
    logic [DW:0] rem_sh;
    logic        take;
    always_comb
    begin
        rem_sh = {rem_reg[DW-1:0], dvd_reg[PW-1]};
        take   = (rem_sh >= {1'b0, den_reg});
    end

    // quotient application with saturation and clamp
    logic [SW-1:0]        qsat;
    logic signed [SW:0]   rsum;
    logic signed [CW-1:0] newc;
    always_comb
    begin
        if (PW > QUOT_LIMIT_LOG2 && quo_reg > PW'(64'd1 << QUOT_LIMIT_LOG2))
            qsat = SW'(64'd1 << QUOT_LIMIT_LOG2);
        else
            qsat = SW'(quo_reg);
        rsum = neg_reg ? (SW+1)'(base_reg) - (SW+1)'(qsat)
                       : (SW+1)'(base_reg) + (SW+1)'(qsat);
        if (zero_den_reg)
            newc = base_reg;
        else if (rsum < -((SW+1)'(1) <<< (CW-1)))
            newc = {1'b1, {(CW-1){1'b0}}};
        else if (rsum > (((SW+1)'(1) <<< (CW-1)) - (SW+1)'(1)))
            newc = {1'b0, {(CW-1){1'b1}}};
        else
            newc = CW'(rsum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x1_reg <= start_x;
            y1_reg <= start_y;
            x2_reg <= end_x;
            y2_reg <= end_y;
            c1_reg <= outcode(start_x, start_y, window_low, window_high);
            c2_reg <= outcode(end_x, end_y, window_low, window_high);
        end
        else if (cmd.prep)
        begin
            x1_reg <= ax;
            y1_reg <= ay;
            x2_reg <= bx;
            y2_reg <= by;
            c1_reg <= ac;
            c2_reg <= swap ? c1_reg : c2_reg;
            axis_y_reg <= sel_y;
            edge_reg <= edge_v;
            base_reg <= sel_y ? ax : ay;
            neg_reg <= (span[DW-1] ^ num[DW-1]) ^ den[DW-1];
            dvd_reg <= prod;
            den_reg <= magd(den);
            zero_den_reg <= (den == '0);
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= CNT_W'(PW);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= take ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[PW-2:0], take};
            dvd_reg <= {dvd_reg[PW-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        else if (cmd.finish)
        begin
            if (axis_y_reg)
            begin
                x1_reg <= newc;
                y1_reg <= edge_reg;
                c1_reg <= outcode(newc, edge_reg, window_low, window_high);
            end
            else
            begin
                x1_reg <= edge_reg;
                y1_reg <= newc;
                c1_reg <= outcode(edge_reg, newc, window_low, window_high);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visible <= 1'b0;
        end
        else if (cmd.result)
        begin
            visible <= cmd.result_vis;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            out_start_x <= cmd.result_vis ? x1_reg : '0;
            out_start_y <= cmd.result_vis ? y1_reg : '0;
            out_end_x   <= cmd.result_vis ? x2_reg : '0;
            out_end_y   <= cmd.result_vis ? y2_reg : '0;
        end
    end

    assign sts.all_inside  = ((c1_reg | c2_reg) == 4'h0);
    assign sts.trivial_rej = ((c1_reg & c2_reg) != 4'h0);
    assign sts.div_last    = (cnt_reg == CNT_W'(1));

endmodule

[hdl/lc2d_ctrl.sv]
module lc2d_ctrl
    import lc2d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  lc2d_sts_t sts,
    output lc2d_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [MOVE_CNT_W-1:0] moves_reg, moves_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        moves_next     = moves_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    moves_next = '0;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (sts.all_inside || sts.trivial_rej ||
                    moves_reg == MOVE_CNT_W'(MOVE_LIMIT))
                begin
                    if (out_free)
                    begin
                        cmd.result     = 1'b1;
                        cmd.result_vis = sts.all_inside;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                moves_next = moves_reg + MOVE_CNT_W'(1);
                state_next = ST_TEST;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            moves_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            moves_reg     <= moves_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/line_clip_2d_outcode.sv]
// Cohen-Sutherland clipping of one 2-D segment against a square window.
// Input channel: in_valid/in_stall carry start_x, start_y, end_x, end_y; a
// transaction happens when in_valid is high and in_stall low at a clock edge.
// Output channel: out_valid/out_stall carry visible and the clipped endpoints,
// possibly swapped; rejected segments give zero coordinates.
// Window bounds come from an APB port: window_low at 0x0, window_high at 0x4.
// A trivially accepted or rejected segment goes from ST_TEST straight to its
// result; each edge move runs through ST_PREP, ST_DIV and ST_FINISH and back
// to ST_TEST; at most 8 moves.
// The moves run through one shared restoring divider, one quotient bit a
// cycle; that divider sets the rate. One segment is in work at a time, so
// in_stall is high from acceptance until the result is loaded.
// The result sits in an output register; a stalled receiver holds it there,
// and the next segment is taken and worked on meanwhile, waiting only to
// load its own result.
// Reset (rst_n, asynchronous, active low) empties the output register and
// sets the window to -2048..2047.
module line_clip_2d_outcode
    import lc2d_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          visible,
    output logic signed [COORD_WIDTH-1:0] out_start_x,
    output logic signed [COORD_WIDTH-1:0] out_start_y,
    output logic signed [COORD_WIDTH-1:0] out_end_x,
    output logic signed [COORD_WIDTH-1:0] out_end_y
);

    logic signed [COORD_WIDTH-1:0] window_low_reg, window_high_reg;
    lc2d_cmd_t cmd;
    lc2d_sts_t sts;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register file; only the low COORD_WIDTH bits are kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= COORD_WIDTH'(-2048);
            window_high_reg <= COORD_WIDTH'(2047);
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == ADDR_WINDOW_LOW)
                window_low_reg <= pwdata[COORD_WIDTH-1:0];
            else
                window_high_reg <= pwdata[COORD_WIDTH-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == ADDR_WINDOW_HIGH)
            prdata = 32'(window_high_reg);
        else
            prdata = 32'(window_low_reg);
    end

    lc2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lc2d_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .window_low  (window_low_reg),
        .window_high (window_high_reg),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .visible     (visible),
        .out_start_x (out_start_x),
        .out_start_y (out_start_y),
        .out_end_x   (out_end_x),
        .out_end_y   (out_end_y)
    );

endmodule

[tb/line_clip_2d_outcode_check.sv]
module line_clip_2d_outcode_check
    import lc2d_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic signed [W-1:0] start_x,
    input  logic signed [W-1:0] start_y,
    input  logic signed [W-1:0] end_x,
    input  logic signed [W-1:0] end_y,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                visible,
    input  logic signed [W-1:0] out_start_x,
    input  logic signed [W-1:0] out_start_y,
    input  logic signed [W-1:0] out_end_x,
    input  logic signed [W-1:0] out_end_y,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic         vis;
        logic [W-1:0] sx;
        logic [W-1:0] sy;
        logic [W-1:0] ex;
        logic [W-1:0] ey;
    } clip_seg_t;

    clip_seg_t    clip_q[$];
    logic [W-1:0] win_lo;
    logic [W-1:0] win_hi;

    localparam longint CMIN = -(longint'(1) <<< (W - 1));
    localparam longint CMAX = (longint'(1) <<< (W - 1)) - 1;

    function automatic logic [3:0] region(longint x, longint y, longint lo, longint hi);
        logic [3:0] c;
        c = '0;
        if (x < lo) c |= OC_LEFT;
        else if (x > hi) c |= OC_RIGHT;
        if (y < lo) c |= OC_BOTTOM;
        else if (y > hi) c |= OC_TOP;
        return c;
    endfunction

    // base + trunc(span*num/den), quotient capped, clamped to coordinate range
    function automatic longint edge_cross(longint base, longint span, longint num,
                                          longint den);
        longint p;
        longint q;
        longint r;
        if (den == 0)
            return base;
        p = span * num;
        q = (p < 0 ? -p : p) / (den < 0 ? -den : den);
        if (q > (longint'(1) <<< QUOT_LIMIT_LOG2))
            q = longint'(1) <<< QUOT_LIMIT_LOG2;
        r = ((p < 0) != (den < 0)) ? base - q : base + q;
        if (r < CMIN) r = CMIN;
        if (r > CMAX) r = CMAX;
        return r;
    endfunction

    function automatic clip_seg_t clip_segment(logic signed [W-1:0] ax,
        logic signed [W-1:0] ay, logic signed [W-1:0] bx, logic signed [W-1:0] by);
        longint     lo, hi, x1, y1, x2, y2, t;
        logic [3:0] c1, c2, tc;
        int         moves;
        clip_seg_t  r;
        lo = longint'($signed(win_lo));
        hi = longint'($signed(win_hi));
        x1 = ax; y1 = ay; x2 = bx; y2 = by;
        c1 = region(x1, y1, lo, hi);
        c2 = region(x2, y2, lo, hi);
        moves = 0;
        r = '0;
        forever
        begin
            if ((c1 | c2) == 0)
            begin
                r.vis = 1'b1;
                r.sx = x1[W-1:0]; r.sy = y1[W-1:0];
                r.ex = x2[W-1:0]; r.ey = y2[W-1:0];
                break;
            end
            if ((c1 & c2) != 0 || moves == MOVE_LIMIT)
                break;
            if (c1 == 0)
            begin
                tc = c1; c1 = c2; c2 = tc;
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            if (c1 & OC_LEFT)
            begin
                y1 = edge_cross(y1, y2 - y1, lo - x1, x2 - x1);
                x1 = lo;
            end
            else if (c1 & OC_RIGHT)
            begin
                y1 = edge_cross(y1, y2 - y1, hi - x1, x2 - x1);
                x1 = hi;
            end
            else if (c1 & OC_BOTTOM)
            begin
                x1 = edge_cross(x1, x2 - x1, lo - y1, y2 - y1);
                y1 = lo;
            end
            else
            begin
                x1 = edge_cross(x1, x2 - x1, hi - y1, y2 - y1);
                y1 = hi;
            end
            moves++;
            c1 = region(x1, y1, lo, hi);
        end
        return r;
    endfunction

    assign pending = clip_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        clip_seg_t e;
        clip_seg_t got;
        if (!rst_n)
        begin
            win_lo     <= W'(-2048);
            win_hi     <= W'(2047);
            fail_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == ADDR_WINDOW_HIGH) win_hi <= pwdata[W-1:0];
                else win_lo <= pwdata[W-1:0];
            end
            if (in_valid && !in_stall)
                clip_q.push_back(clip_segment(start_x, start_y, end_x, end_y));
            if (out_valid && !out_stall)
            begin
                got = {visible, out_start_x, out_start_y, out_end_x, out_end_y};
                if (clip_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transaction %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = clip_q.pop_front();
                    if (got !== e)
                    begin
                        if (fail_count < 10)
                            $display("clip mismatch: exp vis=%0b %0d,%0d %0d,%0d got vis=%0b %0d,%0d %0d,%0d",
                                e.vis, $signed(e.sx), $signed(e.sy), $signed(e.ex), $signed(e.ey),
                                got.vis, $signed(got.sx), $signed(got.sy), $signed(got.ex),
                                $signed(got.ey));
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/line_clip_2d_outcode_test.sv]
module line_clip_2d_outcode_test;
    import lc2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 16;
    localparam int STALL_LIMIT = 5000; // cycles with no transaction at all
    localparam int LONG_HOLD = 600;    // receiver hold-off to fill the block

    logic                clk, rst_n;
    logic                psel, penable, pwrite, pready;
    logic [2:0]          paddr;
    logic [31:0]         pwdata, prdata;
    logic                in_valid, in_stall, out_valid, out_stall, visible;
    logic signed [W-1:0] start_x, start_y, end_x, end_y;
    logic signed [W-1:0] out_start_x, out_start_y, out_end_x, out_end_y;
    int                  fail_count, pending;
    int                  idle_cycles;
    bit                  long_hold;   // request for the long receiver hold-off
    bit                  no_gaps;     // stretch with neither side idling
    logic signed [W-1:0] cur_lo, cur_hi;

    line_clip_2d_outcode #(.COORD_WIDTH(W)) uut (.*);

    line_clip_2d_outcode_check #(.W(W)) chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, the odd long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= (gap_len() != 0);
        end
    end

    // Watchdog: anything moving on either channel resets the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One APB write: setup then access cycle.
    task automatic reg_write(logic addr_hi, logic signed [W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr_hi, 2'b00};
        pwdata  <= 32'($signed(v));
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Window change only once the block has drained; valid drops first so
    // the last segment is not taken again, and the wait before polling pending
    // lets the checker see any transaction of the current edge.
    task automatic set_window(logic signed [W-1:0] lo, logic signed [W-1:0] hi);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        reg_write(ADDR_WINDOW_LOW, lo);
        reg_write(ADDR_WINDOW_HIGH, hi);
        cur_lo = lo;
        cur_hi = hi;
    endtask

    // Offer one segment, hold it until taken, then maybe drop valid for a gap.
    task automatic send_segment(logic signed [W-1:0] ax, logic signed [W-1:0] ay,
                                logic signed [W-1:0] bx, logic signed [W-1:0] by);
        int g;
        in_valid <= 1'b1;
        start_x  <= ax;
        start_y  <= ay;
        end_x    <= bx;
        end_y    <= by;
        do @(posedge clk); while (in_stall);
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Coordinates: full range, near the window edges, or the extremes.
    function automatic logic signed [W-1:0] pick_coord();
        longint v;
        case ($urandom_range(0, 5))
            0, 1: return W'($urandom);
            2, 3:
            begin
                v = longint'(cur_lo) + $signed($urandom_range(0, 200)) - 100;
                if ($urandom_range(0, 1)) v = longint'(cur_hi) + $signed($urandom_range(0, 200)) - 100;
                if (v < -32768) v = -32768;
                if (v > 32767) v = 32767;
                return W'(v);
            end
            4: return $urandom_range(0, 1) ? W'(-32768) : W'(32767);
            default: return $urandom_range(0, 1) ? cur_lo : cur_hi;
        endcase
    endfunction

    task automatic random_segments(int n);
        repeat (n)
            send_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord());
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; start_x = '0; start_y = '0; end_x = '0; end_y = '0;
        long_hold = 1'b0; no_gaps = 1'b0; idle_cycles = 0;
        cur_lo = -2048; cur_hi = 2047;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed set on the reset window.
        send_segment(0, 0, 0, 0);                      // point inside
        send_segment(-2048, -2048, 2047, 2047);        // on the corners
        send_segment(-3000, 0, -2500, 100);            // both left: reject
        send_segment(0, 3000, 100, 2500);              // both top: reject
        send_segment(-5000, 10, 5000, -10);            // left to right crossing
        send_segment(10, -5000, -10, 5000);            // bottom to top crossing
        send_segment(0, 0, 9000, 300);                 // first inside: swapped
        send_segment(100, 100, -100, -9000);           // first inside, bottom exit
        send_segment(-32768, -32768, 32767, 32767);    // full diagonal
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-32768, 32767, -32768, -32768);   // vertical, outside
        send_segment(-3000, 5000, 3000, -5000);        // corner-cutting
        send_segment(-2100, 2100, 2100, 2300);         // misses the corner
        send_segment(500, -32768, 500, 32767);         // vertical through
        send_segment(-32768, 7, 32767, 7);             // horizontal through

        // Long hold-off while the sender keeps offering.
        long_hold = 1'b1;
        random_segments(10);
        random_segments(100);

        // Sender pauses until the block has drained.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        set_window(-32768, 32767);
        random_segments(100);
        set_window(0, 0);
        send_segment(-1, -1, 1, 1);
        random_segments(90);
        set_window(100, -100);                         // inverted window
        send_segment(-200, 0, 200, 0);
        random_segments(100);
        set_window(32767, -32768);                     // inverted extremes
        random_segments(90);
        set_window(-100, 100);
        no_gaps = 1'b1;
        random_segments(100);
        no_gaps = 1'b0;
        set_window(-10, 10);
        random_segments(100);
        set_window(-2048, 2047);
        random_segments(100);

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
